// ----- sv/batch_norm_stats_normalizer_core_defines.svh -----
// Assertion macros used by the RTL of the normaliser core.
`ifndef BATCH_NORM_STATS_NORMALIZER_CORE_DEFINES_SVH
`define BATCH_NORM_STATS_NORMALIZER_CORE_DEFINES_SVH
`ifndef SYNTH
`define BNSN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BNSN_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BNSN_ASSERT(lbl, prop)
`define BNSN_ASSERT_NR(lbl, prop)
`endif
`endif

// ----- sv/bnsn_pkg.sv -----
package bnsn_pkg;

  localparam int FEATURES    = 16;
  localparam int BATCH_DEPTH = 64;
  localparam int FEAT_W      = 4;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = $clog2(BATCH_DEPTH + 1);
  localparam int ADDR_W      = $clog2(FEATURES * BATCH_DEPTH);
  localparam int SUM_W       = VAL_W + $clog2(BATCH_DEPTH);
  localparam int PROD_W      = 2 * VAL_W;
  localparam int DIVN_W      = 2 * VAL_W + $clog2(BATCH_DEPTH);
  localparam int DVS_W       = 16;
  localparam int RAD_W       = 2 * ((DIVN_W + 2) / 2);
  localparam int ROOT_W      = RAD_W / 2;
  localparam int EPS_W       = 16;
  localparam int EPS_RESET   = 17;
  localparam int SIG_RESET   = 4096;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STATS = 2'd1,
    KIND_NORM  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  localparam logic [0:0] REG_EPS = 1'b0;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/batch_norm_stats_normalizer_core.sv -----
// Batch normalisation core. Load words (kind 0) are written straight into the
// sample store; clear words reset the sample count. A statistics word walks
// the store twice per feature (a mean pass, then a squared-deviation pass, each
// over the N stored samples, N being the sample count), and each pass is
// followed by a serial division; the variance division is followed by a square
// root, and the feature's result word is then emitted, sixteen features in
// turn, one result word per feature. A normalise word gives one result word,
// and skips the division when the difference or the deviation is zero.
// A stalled result word holds back the next result word. An empty store makes
// a statistics word give nothing. The sample store has a single read port, and
// one serial divider serves the mean, variance and normalise divisions.
module batch_norm_stats_normalizer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [bnsn_pkg::FEAT_W-1:0]  feature_i,
  input  logic signed [15:0]           value_i,
  input  logic                         end_of_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bnsn_pkg::FEAT_W-1:0]  out_feature_o,
  output logic signed [15:0]           mean_out_o,
  output logic [15:0]                  sigma_out_o,
  output logic [15:0]                  peak_out_o,
  output logic signed [15:0]           normalized_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bnsn_pkg::*;
  `include "batch_norm_stats_normalizer_core_defines.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_P1, ST_MDIV, ST_P2, ST_VDIV, ST_SQRT, ST_EMIT, ST_NDIV, ST_NOUT
  } state_e;

  state_e              state_q;
  logic [EPS_W-1:0]    eps_q;
  logic [CNT_W-1:0]    cnt_q, s_q;
  logic [FEAT_W-1:0]   f_q;
  logic                rd_v_q, prod_v_q, neg_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [VAL_W-1:0]    peak_q;
  logic signed [VAL_W-1:0] mean_cur_q;
  logic [DIVN_W-1:0]   sq_q;
  logic [PROD_W-1:0]   prod_q;
  logic [VAL_W-1:0]    sig_cur_q;
  logic signed [VAL_W-1:0] mean_q [FEATURES];
  logic [VAL_W-1:0]    sig_q [FEATURES];
  div_req_t            div_req_q;
  div_rsp_t            div_rsp;
  logic                sqrt_start_q, sqrt_done;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W-1:0]   root;
  logic                out_valid_q, out_last_q;
  logic [FEAT_W-1:0]   out_feat_q;
  logic signed [VAL_W-1:0] out_mean_q, out_norm_q;
  logic [VAL_W-1:0]    out_sig_q, out_peak_q;
  logic [FEAT_W-1:0]   nrm_feat_q;
  logic signed [VAL_W-1:0] nrm_mean_q, nrm_val_q;
  logic [VAL_W-1:0]    nrm_sig_q;

  logic                in_acc, cfg_wr, mem_we, feat_ok, issue, out_free;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [VAL_W-1:0]    rdata;
  logic signed [VAL_W-1:0] x, mean_sel;
  logic [VAL_W:0]      ax;
  logic signed [VAL_W:0] d, ndiff;
  logic signed [PROD_W+1:0] dsq;
  logic [VAL_W:0]      nmag;
  logic [VAL_W-1:0]    sig_sel;
  logic signed [SUM_W-1:0] sum_abs;
  logic [DIVN_W-1:0]   qneg;

  assign in_acc   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign feat_ok  = 32'(feature_i) < FEATURES;
  assign mem_we   = in_acc && (kind_i == KIND_LOAD) && (32'(cnt_q) < BATCH_DEPTH) && feat_ok;
  assign waddr    = ADDR_W'(32'(cnt_q) * FEATURES + 32'(feature_i));
  assign raddr    = ADDR_W'(32'(s_q) * FEATURES + 32'(f_q));
  assign issue    = (s_q < cnt_q) && (state_q == ST_P1 || state_q == ST_P2);
  assign out_free = !out_valid_q || out_ready_i;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EPS) ? 32'(eps_q) : 32'd0;

  always_comb begin
    x        = signed'(rdata);
    ax       = x[VAL_W-1] ? (VAL_W + 1)'(-(VAL_W + 1)'(x)) : (VAL_W + 1)'(x);
    d        = (VAL_W + 1)'(x) - (VAL_W + 1)'(mean_cur_q);
    dsq      = (PROD_W + 2)'(d * d);
    mean_sel = feat_ok ? mean_q[feature_i] : '0;
    sig_sel  = feat_ok ? sig_q[feature_i] : '0;
    ndiff    = (VAL_W + 1)'(value_i) - (VAL_W + 1)'(mean_sel);
    nmag     = ndiff[VAL_W] ? (VAL_W + 1)'(-ndiff) : (VAL_W + 1)'(ndiff);
    sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;
    qneg     = -div_rsp.quotient;
  end

  bnsn_ram #(.WIDTH(VAL_W), .DEPTH(FEATURES * BATCH_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bnsn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  bnsn_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start_q),
    .radicand_i (rad_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      eps_q        <= EPS_W'(EPS_RESET);
      cnt_q        <= '0;
      s_q          <= '0;
      f_q          <= '0;
      rd_v_q       <= 1'b0;
      prod_v_q     <= 1'b0;
      div_req_q    <= '0;
      sqrt_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < FEATURES; i++) begin
        mean_q[i] <= '0;
        sig_q[i]  <= VAL_W'(SIG_RESET);
      end
    end else begin
      div_req_q.start <= 1'b0;
      sqrt_start_q    <= 1'b0;
      rd_v_q          <= issue;
      prod_v_q        <= rd_v_q && (state_q == ST_P2);
      if (issue) begin
        s_q <= s_q + 1'b1;
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr && paddr[2] == REG_EPS) begin
        eps_q <= pwdata[EPS_W-1:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (kind_i)
              KIND_LOAD: begin
                if (32'(cnt_q) < BATCH_DEPTH && end_of_sample_i) begin
                  cnt_q <= cnt_q + 1'b1;
                end
              end
              KIND_CLEAR: cnt_q <= '0;
              KIND_STATS: begin
                if (cnt_q != '0) begin
                  f_q     <= '0;
                  s_q     <= '0;
                  sum_q   <= '0;
                  peak_q  <= '0;
                  state_q <= ST_P1;
                end
              end
              default: begin
                // The result is built aside so that a waiting result word is left intact.
                nrm_feat_q <= feature_i;
                nrm_mean_q <= mean_sel;
                nrm_sig_q  <= sig_sel;
                neg_q      <= ndiff[VAL_W];
                if (!feat_ok || ndiff == '0) begin
                  nrm_val_q <= '0;
                  state_q   <= ST_NOUT;
                end else if (sig_sel == '0) begin
                  // Zero deviation saturates by the sign of the difference.
                  nrm_val_q <= ndiff[VAL_W] ? VAL_W'(16'sh8000) : VAL_W'(16'sh7fff);
                  state_q   <= ST_NOUT;
                end else begin
                  div_req_q.start    <= 1'b1;
                  div_req_q.dividend <= DIVN_W'({nmag, 12'd0});
                  div_req_q.divisor  <= DVS_W'(sig_sel);
                  state_q            <= ST_NDIV;
                end
              end
            endcase
          end
        end
        ST_P1: begin
          if (rd_v_q) begin
            sum_q <= sum_q + SUM_W'(x);
            if (ax > (VAL_W + 1)'(peak_q)) begin
              peak_q <= VAL_W'(ax);
            end
          end
          if (!issue && !rd_v_q) begin
            neg_q              <= sum_q[SUM_W-1];
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= DIVN_W'(unsigned'(sum_abs));
            div_req_q.divisor  <= DVS_W'(cnt_q);
            state_q            <= ST_MDIV;
          end
        end
        ST_MDIV: begin
          if (div_rsp.done) begin
            mean_cur_q <= neg_q ? VAL_W'(qneg) : VAL_W'(div_rsp.quotient);
            s_q        <= '0;
            sq_q       <= '0;
            state_q    <= ST_P2;
          end
        end
        ST_P2: begin
          if (rd_v_q) begin
            prod_q <= PROD_W'(unsigned'(dsq));
          end
          if (prod_v_q) begin
            sq_q <= sq_q + DIVN_W'(prod_q);
          end
          if (!issue && !rd_v_q && !prod_v_q) begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= sq_q;
            div_req_q.divisor  <= DVS_W'(cnt_q);
            state_q            <= ST_VDIV;
          end
        end
        ST_VDIV: begin
          if (div_rsp.done) begin
            rad_q        <= RAD_W'(div_rsp.quotient) + RAD_W'(eps_q);
            sqrt_start_q <= 1'b1;
            state_q      <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            sig_cur_q <= (root > ROOT_W'(16'hffff)) ? 16'hffff : VAL_W'(root);
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            mean_q[f_q] <= mean_cur_q;
            sig_q[f_q]  <= sig_cur_q;
            out_valid_q <= 1'b1;
            out_feat_q  <= f_q;
            out_mean_q  <= mean_cur_q;
            out_sig_q   <= sig_cur_q;
            out_peak_q  <= peak_q;
            out_norm_q  <= '0;
            out_last_q  <= (32'(f_q) == FEATURES - 1);
            if (32'(f_q) == FEATURES - 1) begin
              state_q <= ST_IDLE;
            end else begin
              f_q     <= f_q + 1'b1;
              s_q     <= '0;
              sum_q   <= '0;
              peak_q  <= '0;
              state_q <= ST_P1;
            end
          end
        end
        ST_NDIV: begin
          if (div_rsp.done) begin
            if (neg_q) begin
              nrm_val_q <= (div_rsp.quotient > DIVN_W'(32768)) ? VAL_W'(16'sh8000)
                                                                : VAL_W'(qneg);
            end else begin
              nrm_val_q <= (div_rsp.quotient > DIVN_W'(32767)) ? VAL_W'(16'sh7fff)
                                                                : VAL_W'(div_rsp.quotient);
            end
            state_q <= ST_NOUT;
          end
        end
        ST_NOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_feat_q  <= nrm_feat_q;
            out_mean_q  <= nrm_mean_q;
            out_sig_q   <= nrm_sig_q;
            out_norm_q  <= nrm_val_q;
            out_peak_q  <= '0;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_feature_o = out_feat_q;
  assign mean_out_o    = out_mean_q;
  assign sigma_out_o   = out_sig_q;
  assign peak_out_o    = out_peak_q;
  assign normalized_o  = out_norm_q;
  assign last_o        = out_last_q;

  // The fill count never passes the store depth.
  `BNSN_ASSERT(a_cnt_range, 32'(cnt_q) <= BATCH_DEPTH)
  // The store is only written while no statistics pass reads it.
  `BNSN_ASSERT(a_we_idle, mem_we |-> (state_q == ST_IDLE))
  // The divider is never left running once the block is idle again.
  `BNSN_ASSERT(a_div_idle, (state_q == ST_IDLE) |-> !div_rsp.busy)
  // A stalled result word keeps its payload.
  `BNSN_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(normalized_o))
  // Register writes never wait.
  `BNSN_ASSERT_NR(a_pready, pready)

endmodule

// ----- sv/bnsn_ram.sv -----
module bnsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/bnsn_div.sv -----
module bnsn_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bnsn_pkg::div_req_t req_i,
  output bnsn_pkg::div_rsp_t rsp_o
);
  import bnsn_pkg::*;

  localparam int STEP_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d, dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  // Restoring division: one quotient bit per cycle, most significant first.
  always_comb begin
    rem_sh = {rem_q, quo_q[DIVN_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_d  = fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
    quo_d  = {quo_q[DIVN_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIVN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- sv/bnsn_sqrt.sv -----
module bnsn_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bnsn_pkg::RAD_W-1:0] radicand_i,
  output logic                       done_o,
  output logic [bnsn_pkg::ROOT_W-1:0] root_o
);
  import bnsn_pkg::*;

  localparam int STEP_W = $clog2(ROOT_W + 1);
  localparam int REM_W  = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [REM_W+1:0]  rem_sh, trial;
  logic              fits;

  // Two radicand bits per cycle; the trial subtrahend is 4*root + 1.
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = (REM_W + 2)'({root_q, 2'b01});
    fits   = rem_sh >= trial;
    rem_d  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
